>>> rtl/cz_pkg.sv
// Shared types and constants of the zero-padded 3x3 convolution block.
// No dependencies; cz_conv, conv2d_zero_padded and the testbench import this package.
`default_nettype none

package cz_pkg;

    localparam int CHANNELS     = 3;
    localparam int KERNEL_SIZE  = 3;
    localparam int PIX_W        = 8;
    localparam int PIXEL_W      = PIX_W * CHANNELS;
    localparam int COEF_W       = 16;
    localparam int KROW_W       = COEF_W * KERNEL_SIZE;
    localparam int OUT_W        = 28;
    localparam int PROD_W       = PIX_W + 1 + COEF_W;
    localparam int ROWSUM_W     = PROD_W + 2;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_IDX_W    = 3;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [KROW_W-1:0]       KTOP_RESET   = 48'd0;
    localparam logic [KROW_W-1:0]       KMID_RESET   = 48'd1024;
    localparam logic [KROW_W-1:0]       KBOT_RESET   = 48'd0;

    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = 3;
    localparam int FIFO_CNT_W   = 4;
    localparam int OCC_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_red;
        logic signed [OUT_W-1:0] out_green;
        logic signed [OUT_W-1:0] out_blue;
        logic                    last_of_frame;
    } out_t;

    // Window taps indexed [row][column], channel c in bits PIX_W*c and up.
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_W-1:0] window_t;
    typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;

    typedef struct packed {
        logic valid;
        logic last;
    } conv_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [OCC_W-1:0] occupancy;
    } conv_stat_t;

endpackage

`default_nettype wire

>>> rtl/cz_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; a read of the address being written returns the old data.
`default_nettype none

module cz_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/cz_conv.sv
// Multiply-accumulate pipeline: masked 3x3 taps times the shared kernel.
// Depends on cz_pkg. Four register stages: taps, products, row sums, total.
`default_nettype none

module cz_conv
    import cz_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire conv_ctl_t  in_ctl,
    input  wire window_t    in_taps,
    input  wire kernel_t    kernel,
    output conv_stat_t      stat,
    output out_t            out_data
);

    logic    va_reg, vb_reg, vc_reg, vd_reg;
    logic    la_reg, lb_reg, lc_reg, ld_reg;
    window_t taps_reg;

    logic signed [PROD_W-1:0]   prod_reg   [CHANNELS][KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0]   prod_next  [CHANNELS][KERNEL_SIZE][KERNEL_SIZE];
    logic signed [ROWSUM_W-1:0] rsum_reg   [CHANNELS][KERNEL_SIZE];
    logic signed [ROWSUM_W-1:0] rsum_next  [CHANNELS][KERNEL_SIZE];
    logic signed [OUT_W-1:0]    total_reg  [CHANNELS];
    logic signed [OUT_W-1:0]    total_next [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            va_reg <= in_ctl.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        la_reg    <= in_ctl.last;
        lb_reg    <= la_reg;
        lc_reg    <= lb_reg;
        ld_reg    <= lc_reg;
        taps_reg  <= in_taps;
        prod_reg  <= prod_next;
        rsum_reg  <= rsum_next;
        total_reg <= total_next;
    end

    // Samples are unsigned, so each gets a zero sign bit before the signed multiply.
    always_comb begin
        logic signed [PIX_W:0]    sample;
        logic signed [COEF_W-1:0] coef;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    sample = $signed({1'b0, taps_reg[r][c][PIX_W*ch +: PIX_W]});
                    coef   = $signed(kernel[r][COEF_W*c +: COEF_W]);
                    prod_next[ch][r][c] = sample * coef;
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                rsum_next[ch][r] = ROWSUM_W'(prod_reg[ch][r][0])
                                 + ROWSUM_W'(prod_reg[ch][r][1])
                                 + ROWSUM_W'(prod_reg[ch][r][2]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            total_next[ch] = OUT_W'(rsum_reg[ch][0])
                           + OUT_W'(rsum_reg[ch][1])
                           + OUT_W'(rsum_reg[ch][2]);
        end
    end

    always_comb begin
        stat.valid     = vd_reg;
        stat.occupancy = OCC_W'(va_reg) + OCC_W'(vb_reg) + OCC_W'(vc_reg) + OCC_W'(vd_reg);
        out_data.out_red       = total_reg[0];
        out_data.out_green     = total_reg[1];
        out_data.out_blue      = total_reg[2];
        out_data.last_of_frame = ld_reg;
    end

endmodule

`default_nettype wire

>>> rtl/conv2d_zero_padded.sv
// Streaming 3x3 correlation of RGB pixels with zero padding at the image edges.
// Depends on cz_pkg, cz_ram and cz_conv.
//
// The block takes one item per clock while s_ready is high and gives at most one
// result per item; a result is completed by the transfer one row plus one pixel
// after its center pixel and passes s1_reg, cz_conv and the result FIFO. The two
// previous rows sit in one line-store RAM with one write and one registered read
// per cycle; each item reads its column, and the next cycle writes the shifted
// pair back, so the single RAM port pair is what sets the rate of one item per
// clock. An eight-entry result FIFO lets input transfers continue while m_ready
// is low; s_ready drops only when the items in flight could fill it. After the
// last pixel of a frame, w+1 flush items (mode high) drain the final row,
// w being image_width held to 1..MAX_WIDTH. The line store is not cleared after
// reset: every entry a result could read before it is written falls in the zero
// padding. Configuration writes are expected only while the block is idle.
`default_nettype none

module conv2d_zero_padded
    import cz_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int LS_W = 2 * PIXEL_W;

    typedef struct packed {
        logic [CW-1:0]      addr;
        logic [PIXEL_W-1:0] pix;
        logic               emit;
        logic               last;
        logic               first_col;
        logic               last_col;
        logic               top_row;
        logic               bottom_row;
    } s1_t;

    // Configuration.
    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    kernel_t                 kernel_reg;

    // Frame position of the next item.
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Item decode at transfer time.
    logic [EW-1:0]    width_ext, w_eff_ext;
    logic [WW-1:0]    w_eff, wm1, col_ext, x_ext, x_inc;
    logic [CW-1:0]    x;
    logic [ROW_W-1:0] h_eff, hm1, orow;
    logic             x_is0, have_row, emit, row_top, row_bot, col_first, last;
    logic             s_fire;
    s1_t              s1_next;

    // Line-store read stage.
    logic             s1_valid_reg;
    s1_t              s1_reg;
    logic [LS_W-1:0]  ram_rdata, ls_data;
    logic             fwd_valid_reg;
    logic [CW-1:0]    fwd_addr_reg;
    logic [LS_W-1:0]  fwd_data_reg;
    logic [PIXEL_W-1:0] top_pix, mid_pix;
    window_t          win_reg;
    window_t          taps;
    conv_ctl_t        conv_ctl;
    conv_stat_t       conv_stat;
    out_t             conv_out;

    // Result FIFO.
    out_t                  fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0] pending;
    logic                  push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            kernel_reg[0]    <= KTOP_RESET;
            kernel_reg[1]    <= KMID_RESET;
            kernel_reg[2]    <= KBOT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:   image_width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                CFG_KERNEL_TOP:    kernel_reg[0]    <= cfg_wdata[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: kernel_reg[1]    <= cfg_wdata[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: kernel_reg[2]    <= cfg_wdata[KROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Position bookkeeping needs no line-store data, so it is settled at transfer
    // time and the next item always sees up-to-date counters.
    always_comb begin
        width_ext = EW'(image_width_reg);
        if (image_width_reg == '0) begin
            w_eff_ext = EW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            w_eff_ext = EW'(MAX_WIDTH);
        end else begin
            w_eff_ext = width_ext;
        end
        w_eff = w_eff_ext[WW-1:0];
        wm1   = w_eff - WW'(1);

        if (image_height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (image_height_reg > ROW_W'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
        hm1 = h_eff - ROW_W'(1);

        col_ext = WW'(col_reg);
        x_ext   = (col_ext >= w_eff) ? wm1 : col_ext;
        x       = x_ext[CW-1:0];
        x_is0   = (x_ext == '0);

        // At column zero the pending result is the right edge of the row two back.
        if (x_is0) begin
            have_row  = (row_reg >= ROW_W'(2));
            orow      = row_reg - ROW_W'(2);
            col_first = (wm1 == '0);
        end else begin
            have_row  = (row_reg >= ROW_W'(1));
            orow      = row_reg - ROW_W'(1);
            col_first = (x_ext == WW'(1));
        end
        emit    = have_row && (orow < h_eff);
        row_top = (orow == '0);
        row_bot = (orow == hm1);
        last    = emit && x_is0 && row_bot;

        x_inc = x_ext + WW'(1);
        if (x_inc >= w_eff) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = x_inc[CW-1:0];
            row_next = row_reg;
        end
        if (last || (row_next > (h_eff + ROW_W'(1)))) begin
            col_next = '0;
            row_next = '0;
        end

        s1_next.addr       = x;
        s1_next.pix        = s_data.mode ? '0
                           : {s_data.pixel_blue, s_data.pixel_green, s_data.pixel_red};
        s1_next.emit       = emit;
        s1_next.last       = last;
        s1_next.first_col  = col_first;
        s1_next.last_col   = x_is0;
        s1_next.top_row    = row_top;
        s1_next.bottom_row = row_bot;
    end

    assign pending = FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(conv_stat.occupancy)
                   + fifo_cnt_reg;
    assign s_ready = (pending < FIFO_CNT_W'(FIFO_DEPTH));
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg  <= s_fire;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg       <= s1_next;
        fwd_addr_reg <= s1_reg.addr;
        fwd_data_reg <= {mid_pix, s1_reg.pix};
    end

    // Each entry holds the row two back in the upper half, the previous row below.
    cz_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_reg.addr),
        .wr_data ({mid_pix, s1_reg.pix}),
        .rd_addr (x),
        .rd_data (ram_rdata)
    );

    // With a one-pixel row consecutive items hit the same entry; the read then
    // missed the write of the cycle before, so that write is forwarded.
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_reg.addr)) begin
            ls_data = fwd_data_reg;
        end else begin
            ls_data = ram_rdata;
        end
        top_pix = ls_data[LS_W-1:PIXEL_W];
        mid_pix = ls_data[PIXEL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_valid_reg) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_pix;
            win_reg[1][2] <= mid_pix;
            win_reg[2][2] <= s1_reg.pix;
        end
    end

    // The window after the shift, with the right column padded at the row end
    // and the image borders forced to zero.
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            taps[r][0] = win_reg[r][1];
            taps[r][1] = win_reg[r][2];
        end
        taps[0][2] = s1_reg.last_col ? '0 : top_pix;
        taps[1][2] = s1_reg.last_col ? '0 : mid_pix;
        taps[2][2] = s1_reg.last_col ? '0 : s1_reg.pix;
        if (s1_reg.first_col) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                taps[r][0] = '0;
            end
        end
        if (s1_reg.top_row) begin
            taps[0] = '0;
        end
        if (s1_reg.bottom_row) begin
            taps[2] = '0;
        end
        conv_ctl.valid = s1_valid_reg && s1_reg.emit;
        conv_ctl.last  = s1_reg.last;
    end

    cz_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (conv_ctl),
        .in_taps  (taps),
        .kernel   (kernel_reg),
        .stat     (conv_stat),
        .out_data (conv_out)
    );

    // The transfer credit in s_ready guarantees a free FIFO slot for every push.
    assign push    = conv_stat.valid;
    assign pop     = m_valid && m_ready;
    assign m_valid = (fifo_cnt_reg != '0);
    assign m_data  = fifo_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                fifo_cnt_reg <= fifo_cnt_reg - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= conv_out;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_conv2d_zero_padded.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv2d_zero_padded: a line-buffer predictor of the
// 3x3 zero-padded correlation checks every result. Depends on cz_pkg and the RTL.
module tb_conv2d_zero_padded;
    import cz_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 4000;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;

    // Shadow copy of the registers and of the block's internal state.
    logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    kernel_t                 kernel_reg = {KBOT_RESET, KMID_RESET, KTOP_RESET};
    logic [PIXEL_W-1:0]      line_mem [2*MAX_W];
    logic [PIXEL_W-1:0]      window [KERNEL_SIZE][KERNEL_SIZE];
    int                      col_pos = 0;
    int                      row_pos = 0;

    in_t         pixel_stream [$];
    out_t        filtered_queue [$];
    int unsigned queued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned error_count = 0;

    conv2d_zero_padded #(.MAX_WIDTH(MAX_W)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        clamp_dim = (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Advances the shadow state by one input item; returns 1 when a pixel leaves.
    function automatic bit filter_step(input in_t item, output out_t res);
        int w, h, x, y, orow, ocol, r, c, ch;
        int sums [CHANNELS];
        logic [PIXEL_W-1:0] pix, top, mid;
        logic [PIXEL_W-1:0] taps [KERNEL_SIZE][KERNEL_SIZE];
        logic signed [COEF_W-1:0] coef;
        bit have, last;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = row_pos;
        pix = (item.mode == MODE_FLUSH) ? '0
            : {item.pixel_blue, item.pixel_green, item.pixel_red};
        have = 1'b0;
        orow = -1;
        ocol = 0;
        res = '0;
        filter_step = 1'b0;
        // At the start of a row the window still holds the end of the previous
        // row, so that row's last pixel is produced now with right padding.
        if (x == 0) begin
            orow = y - 2;
            ocol = w - 1;
            for (r = 0; r < KERNEL_SIZE; r++) begin
                taps[r][0] = window[r][1];
                taps[r][1] = window[r][2];
                taps[r][2] = '0;
            end
            have = 1'b1;
        end
        top = line_mem[MAX_W + x];
        mid = line_mem[x];
        line_mem[MAX_W + x] = mid;
        line_mem[x] = pix;
        for (r = 0; r < KERNEL_SIZE; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = pix;
        if (x != 0) begin
            orow = y - 1;
            ocol = x - 1;
            for (r = 0; r < KERNEL_SIZE; r++)
                for (c = 0; c < KERNEL_SIZE; c++)
                    taps[r][c] = window[r][c];
            have = 1'b1;
        end
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
        if (have && orow >= 0 && orow < h) begin
            last = (orow == h - 1) && (ocol == w - 1);
            for (r = 0; r < KERNEL_SIZE; r++) begin
                for (c = 0; c < KERNEL_SIZE; c++) begin
                    if ((ocol == 0 && c == 0) || (orow == 0 && r == 0) ||
                        (orow == h - 1 && r == KERNEL_SIZE - 1))
                        taps[r][c] = '0;
                end
            end
            for (ch = 0; ch < CHANNELS; ch++) begin
                sums[ch] = 0;
                for (r = 0; r < KERNEL_SIZE; r++) begin
                    for (c = 0; c < KERNEL_SIZE; c++) begin
                        coef = kernel_reg[r][COEF_W*c +: COEF_W];
                        sums[ch] += int'(taps[r][c][PIX_W*ch +: PIX_W]) * int'(coef);
                    end
                end
            end
            res.out_red = sums[0][OUT_W-1:0];
            res.out_green = sums[1][OUT_W-1:0];
            res.out_blue = sums[2][OUT_W-1:0];
            res.last_of_frame = last;
            filter_step = 1'b1;
            if (last) begin
                col_pos = 0;
                row_pos = 0;
            end
        end
        if (row_pos > h + 1) begin
            col_pos = 0;
            row_pos = 0;
        end
    endfunction

    function automatic in_t make_item(input logic mode, input logic [PIX_W-1:0] red,
                                      input logic [PIX_W-1:0] green,
                                      input logic [PIX_W-1:0] blue);
        make_item.mode = mode;
        make_item.pixel_red = red;
        make_item.pixel_green = green;
        make_item.pixel_blue = blue;
    endfunction

    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: rand_sample = '0;
            1: rand_sample = '1;
            default: rand_sample = $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0: rand_coef = 16'h7FFF;
            1: rand_coef = 16'h8000;
            2: rand_coef = '0;
            3: rand_coef = 16'h0400;
            4, 5: rand_coef = $urandom;
            default: rand_coef = 16'($urandom_range(0, 4095)) - 16'd2048;
        endcase
    endfunction

    function automatic kernel_t rand_kernel();
        int r;
        for (r = 0; r < KERNEL_SIZE; r++)
            rand_kernel[r] = {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    task automatic enqueue(input in_t item);
        pixel_stream.push_back(item);
        queued_total++;
    endtask

    // One frame at the current size, then the flush ticks that drain it. With
    // noise, some pixels become flushes and some flushes become pixels.
    task automatic queue_frame(input int noise);
        int fw, fh, k;
        bit odd;
        fw = clamp_dim(width_reg, MAX_W);
        fh = clamp_dim(height_reg, MAX_HEIGHT);
        for (k = 0; k < fw * fh + fw + 1; k++) begin
            odd = ($urandom_range(0, 99) < noise);
            enqueue(make_item(((k < fw * fh) ^ odd) ? MODE_PIXEL : MODE_FLUSH,
                              rand_sample(), rand_sample(), rand_sample()));
        end
    endtask

    task automatic drain_block();
        while (accepted_total != queued_total || filtered_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [WIDTH_REG_W-1:0] w,
                                  input logic [HEIGHT_REG_W-1:0] h, input kernel_t k);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_index <= CFG_KERNEL_TOP;
        cfg_wdata <= k[0];
        @(posedge aclk);
        cfg_index <= CFG_KERNEL_MIDDLE;
        cfg_wdata <= k[1];
        @(posedge aclk);
        cfg_index <= CFG_KERNEL_BOTTOM;
        cfg_wdata <= k[2];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
        height_reg = h;
        kernel_reg = k;
    endtask

    task automatic check_field(input string label, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Input side: one item per transfer, with a random gap after each one.
    always @(posedge aclk) begin : feeder
        out_t predicted;
        int unsigned in_gap;
        bit calm_in;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (filter_step(s_data, predicted))
                    filtered_queue.push_back(predicted);
                accepted_total++;
                if ($urandom_range(0, 63) == 0)
                    calm_in = !calm_in;
                in_gap = calm_in ? 0 : $urandom_range(0, 12);
            end
            if (!s_valid || s_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_stream.size() != 0) begin
                    s_data <= pixel_stream.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each transfer with the oldest prediction, then stall.
    always @(posedge aclk) begin : sink
        out_t want;
        int unsigned out_stall;
        bit calm_out;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (filtered_queue.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected: %0d %0d %0d last %0b",
                             $time, m_data.out_red, m_data.out_green, m_data.out_blue,
                             m_data.last_of_frame);
                end else begin
                    want = filtered_queue.pop_front();
                    check_field("out_red", want.out_red, m_data.out_red);
                    check_field("out_green", want.out_green, m_data.out_green);
                    check_field("out_blue", want.out_blue, m_data.out_blue);
                    check_field("last_of_frame", want.last_of_frame, m_data.last_of_frame);
                end
                if ($urandom_range(0, 63) == 0)
                    calm_out = !calm_out;
                out_stall = calm_out ? 0 : $urandom_range(0, 12);
            end
            if (out_stall > 0) begin
                m_ready <= 1'b0;
                if (m_valid)
                    out_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_conv2d_zero_padded: errors");
        $finish;
    end

    initial begin : sequencer
        kernel_t kern;
        int k, f, nframes, noise, base;
        logic [WIDTH_REG_W-1:0] w_sel;
        logic [HEIGHT_REG_W-1:0] h_sel;
        for (k = 0; k < 2 * MAX_W; k++)
            line_mem[k] = '0;
        for (k = 0; k < KERNEL_SIZE * KERNEL_SIZE; k++)
            window[k / KERNEL_SIZE][k % KERNEL_SIZE] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // 2x2 frame with extreme taps, a flush inside the image and a pixel
        // standing in for one of the trailing flushes.
        kern[0] = {16'h7FFF, 16'h8000, 16'h7FFF};
        kern[1] = {16'h8000, 16'h7FFF, 16'h0400};
        kern[2] = {16'hFFFF, 16'h0001, 16'h8000};
        apply_settings(11'd2, 13'd2, kern);
        enqueue(make_item(MODE_PIXEL, 8'd255, 8'd0, 8'd255));
        enqueue(make_item(MODE_PIXEL, 8'd0, 8'd255, 8'd0));
        enqueue(make_item(MODE_FLUSH, 8'd255, 8'd255, 8'd255));
        enqueue(make_item(MODE_PIXEL, 8'd1, 8'd128, 8'd254));
        enqueue(make_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
        enqueue(make_item(MODE_PIXEL, 8'd7, 8'd7, 8'd7));
        enqueue(make_item(MODE_FLUSH, 8'd170, 8'd85, 8'd170));
        drain_block();

        // Zero width and height act as a single pixel; most negative taps.
        kern = {KERNEL_SIZE{{KERNEL_SIZE{16'h8000}}}};
        apply_settings(11'd0, 13'd0, kern);
        enqueue(make_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255));
        enqueue(make_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
        enqueue(make_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
        drain_block();

        // Largest positive sum: every tap at its maximum over a full window.
        kern = {KERNEL_SIZE{{KERNEL_SIZE{16'h7FFF}}}};
        apply_settings(11'd3, 13'd3, kern);
        for (k = 0; k < 9; k++)
            enqueue(make_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255));
        for (k = 0; k < 4; k++)
            enqueue(make_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0));
        drain_block();

        // Random frames, mostly well formed, a few with swapped pixels and flushes.
        base = queued_total;
        while (queued_total - base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: w_sel = '0;
                1, 2: w_sel = $urandom_range(9, 40);
                default: w_sel = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0: h_sel = '0;
                1, 2: h_sel = $urandom_range(9, 24);
                default: h_sel = $urandom_range(1, 8);
            endcase
            apply_settings(w_sel, h_sel, rand_kernel());
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                noise = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 20);
                queue_frame(noise);
            end
            drain_block();
        end

        // Widest and tallest frames, including register values beyond the limits.
        apply_settings(11'd1024, 13'd1, rand_kernel());
        queue_frame(0);
        drain_block();
        apply_settings(11'd2047, 13'd0, rand_kernel());
        queue_frame(2);
        drain_block();
        apply_settings(11'd1, 13'd8191, rand_kernel());
        queue_frame(0);
        drain_block();

        if (error_count == 0)
            $display("tb_conv2d_zero_padded: clean");
        else
            $display("tb_conv2d_zero_padded: errors");
        $finish;
    end

endmodule
